// ----- sv/stb_pkg.sv -----
// Shared constants, codes and handshake types for the software timer bank.
// No dependencies; imported by the controller, the datapath and the top level.
package stb_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int MAX_EXPIRE = 10;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int EXP_W      = $clog2(MAX_EXPIRE + 1);

    localparam logic [15:0] TPS_RESET = 16'd100;

    // command codes
    localparam logic [2:0] ACT_START_TICKS = 3'd0;
    localparam logic [2:0] ACT_START_SECS  = 3'd1;
    localparam logic [2:0] ACT_STOP        = 3'd2;
    localparam logic [2:0] ACT_RESET       = 3'd3;
    localparam logic [2:0] ACT_RUN         = 3'd4;
    localparam logic [2:0] ACT_QUERY       = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_EVENT  = 2'd1;
    localparam logic [1:0] KIND_FIN    = 2'd2;

    typedef struct packed {
        logic load;       // capture the incoming word
        logic mul;        // form seconds * tick rate
        logic exec;       // apply a slot command and post its status
        logic scan_step;  // process one slot of a run
        logic fin;        // post the run-finished word
    } stb_cmd_t;

    typedef struct packed {
        logic [2:0] in_action;  // action field of the word on the input
        logic       out_free;   // output register can take a word this cycle
        logic       scan_emit;  // current slot expires and needs the output
        logic       scan_last;  // current slot is the last one
    } stb_stat_t;

endpackage

// ----- sv/stb_ctrl.sv -----
// Sequencing state machine of the timer bank: accepts a word, steps the
// datapath through multiply, execute or the slot scan. Depends on stb_pkg.
module stb_ctrl
    import stb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  stb_stat_t stat,
    output stb_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_EXEC = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (stat.in_action == ACT_RUN)
                        state_next = ST_SCAN;
                    else if (stat.in_action == ACT_START_SECS)
                        state_next = ST_MUL;
                    else
                        state_next = ST_EXEC;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                // hold on an expiring slot until the output register frees up
                if (!stat.scan_emit || stat.out_free)
                begin
                    cmd.scan_step = 1'b1;
                    if (stat.scan_last)
                        state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- sv/stb_dp.sv -----
// Datapath of the timer bank: slot state, command registers, multiplier,
// scan counters and the output register. Depends on stb_pkg.
module stb_dp
    import stb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic [71:0] s_tdata,    // action, timer_slot, tick_count, seconds, owner_task, new_id
    input  stb_cmd_t    cmd,
    output stb_stat_t   stat,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // event_task, event_id, ticks_left, is_running, has_expired
    output logic [1:0]  m_tuser,    // kind
    output logic        m_tlast     // last
);

    logic [15:0]      tps_reg;
    logic [31:0]      rem_reg [NUM_TIMERS];
    logic [7:0]       own_reg [NUM_TIMERS];
    logic [7:0]       id_reg  [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] run_reg;
    logic [NUM_TIMERS-1:0] exp_reg;

    logic [2:0]  act_reg;
    logic [3:0]  slot_reg;
    logic [31:0] ticks_reg;
    logic [15:0] secs_reg;
    logic [7:0]  task_reg;
    logic [7:0]  nid_reg;
    logic [31:0] prod_reg;

    logic [IDX_W-1:0] idx_reg;
    logic [EXP_W-1:0] ecnt_reg;

    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [7:0]  out_task_reg;
    logic [7:0]  out_id_reg;
    logic [31:0] out_left_reg;
    logic        out_run_reg;
    logic        out_exp_reg;
    logic        out_last_reg;

    // single read/write address: scan index during a run, else the command slot
    logic [IDX_W-1:0] addr;
    logic [31:0] rem_cur;
    logic        run_cur;
    logic        exp_cur;
    logic [7:0]  own_cur;
    logic [7:0]  id_cur;
    logic        slot_ok;
    logic        due;
    logic        scan_emit;

    logic        wr_en;
    logic [31:0] wr_rem;
    logic        wr_run;
    logic        wr_exp;
    logic [7:0]  wr_own;
    logic [7:0]  wr_id;

    logic        out_load;
    logic [1:0]  out_kind_next;
    logic [7:0]  out_task_next;
    logic [7:0]  out_id_next;
    logic [31:0] out_left_next;
    logic        out_run_next;
    logic        out_exp_next;
    logic        out_last_next;

    assign addr    = (act_reg == ACT_RUN) ? idx_reg : IDX_W'(slot_reg);
    assign rem_cur = rem_reg[addr];
    assign run_cur = run_reg[addr];
    assign exp_cur = exp_reg[addr];
    assign own_cur = own_reg[addr];
    assign id_cur  = id_reg[addr];
    assign slot_ok = (9'(slot_reg) < 9'(NUM_TIMERS));

    assign due       = !(ticks_reg < rem_cur);
    assign scan_emit = run_cur && due && (ecnt_reg < EXP_W'(MAX_EXPIRE));

    assign stat.in_action = s_tdata[2:0];
    assign stat.out_free  = !out_valid_reg || m_tready;
    assign stat.scan_emit = scan_emit;
    assign stat.scan_last = (idx_reg == IDX_W'(NUM_TIMERS - 1));

    always_comb
    begin
        wr_en         = 1'b0;
        wr_rem        = rem_cur;
        wr_run        = run_cur;
        wr_exp        = exp_cur;
        wr_own        = own_cur;
        wr_id         = id_cur;
        out_load      = 1'b0;
        out_kind_next = KIND_STATUS;
        out_task_next = '0;
        out_id_next   = '0;
        out_left_next = '0;
        out_run_next  = 1'b0;
        out_exp_next  = 1'b0;
        out_last_next = 1'b1;

        if (cmd.exec)
        begin
            case (act_reg)
                ACT_START_TICKS:
                begin
                    wr_rem = ticks_reg;
                    wr_own = task_reg;
                    wr_run = 1'b1;
                end
                ACT_START_SECS:
                begin
                    wr_rem = prod_reg;
                    wr_own = task_reg;
                    wr_run = 1'b1;
                end
                ACT_STOP:
                begin
                    wr_run = 1'b0;
                end
                ACT_RESET:
                begin
                    wr_run = 1'b0;
                    wr_exp = 1'b0;
                    wr_rem = '0;
                    wr_id  = nid_reg;
                end
                default:
                begin
                end
            endcase
            wr_en    = slot_ok;
            out_load = 1'b1;
            if (slot_ok)
            begin
                out_task_next = wr_own;
                out_id_next   = wr_id;
                out_left_next = wr_rem;
                out_run_next  = wr_run;
                out_exp_next  = wr_exp;
            end
        end
        else if (cmd.scan_step)
        begin
            wr_en = run_cur;
            if (!due)
                wr_rem = rem_cur - ticks_reg;
            else if (!scan_emit)
                wr_rem = 32'd1;  // postpone to the next run
            else
            begin
                wr_rem        = '0;
                wr_run        = 1'b0;
                wr_exp        = 1'b1;
                out_load      = 1'b1;
                out_kind_next = KIND_EVENT;
                out_task_next = own_cur;
                out_id_next   = id_cur;
                out_exp_next  = 1'b1;
                out_last_next = 1'b0;
            end
        end
        else if (cmd.fin)
        begin
            out_load      = 1'b1;
            out_kind_next = KIND_FIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= TPS_RESET;
            run_reg <= '0;
            exp_reg <= '0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                rem_reg[i] <= '0;
                own_reg[i] <= '0;
                id_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
                tps_reg <= cfg_wr_data;
            if (wr_en)
            begin
                rem_reg[addr] <= wr_rem;
                run_reg[addr] <= wr_run;
                exp_reg[addr] <= wr_exp;
                own_reg[addr] <= wr_own;
                id_reg[addr]  <= wr_id;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= ACT_QUERY;
            idx_reg  <= '0;
            ecnt_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                act_reg  <= s_tdata[2:0];
                idx_reg  <= '0;
                ecnt_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (scan_emit)
                    ecnt_reg <= ecnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            slot_reg  <= s_tdata[6:3];
            ticks_reg <= s_tdata[38:7];
            secs_reg  <= s_tdata[54:39];
            task_reg  <= s_tdata[62:55];
            nid_reg   <= s_tdata[70:63];
        end
        if (cmd.mul)
            prod_reg <= 32'(secs_reg) * 32'(tps_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg <= out_kind_next;
            out_task_reg <= out_task_next;
            out_id_reg   <= out_id_next;
            out_left_reg <= out_left_next;
            out_run_reg  <= out_run_next;
            out_exp_reg  <= out_exp_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_exp_reg, out_run_reg, out_left_reg, out_id_reg, out_task_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    a_ecnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ecnt_reg <= EXP_W'(MAX_EXPIRE))
        else $error("expire count past limit");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_step && scan_emit) |=> (out_valid_reg && out_kind_reg == KIND_EVENT))
        else $error("timeout event not posted");

    a_event_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_EVENT) |->
            (out_left_reg == 32'd0 && !out_run_reg && out_exp_reg && !out_last_reg))
        else $error("malformed timeout event");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !out_load)
        else $error("output register overwritten while stalled");

endmodule

// ----- sv/software_timer_bank_unit.sv -----
// Software timer bank: 16 countdown slots driven by streamed commands.
// A slot command's status word is loaded into the output register from the execute state once
// that register is free; start-in-seconds goes through the 16x16 multiplier state first.
// A new word is accepted only in idle, after the previous command or run is done; a run visits
// one slot per cycle, holding on an expiring slot while the output register is not free.
// Reset clears all slots at once; the tick-rate register resets to 100.
module software_timer_bank_unit
    import stb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,    // action, timer_slot, tick_count, seconds, owner_task, new_id
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // event_task, event_id, ticks_left, is_running, has_expired
    output logic [1:0]  m_tuser,    // kind
    output logic        m_tlast     // last
);

    stb_cmd_t  cmd;
    stb_stat_t stat;

    stb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    stb_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
